/* hdl/ors_pkg.sv */
// Shared types and constants of the 1-Wire ROM search engine.
`timescale 1ns / 1ps

package ors_pkg;

    localparam int ROM_BITS     = 64;
    localparam int POS_W        = 7;
    localparam int IDX_W        = 6;
    localparam int CRC_W        = 8;
    localparam int FAM_W        = 4;
    localparam int COUNT_W      = 8;

    localparam logic [POS_W-1:0]   FAMILY_LIMIT = 7'd9;
    localparam logic [POS_W-1:0]   LAST_BIT_POS = 7'd64;
    localparam logic [CRC_W-1:0]   CRC_POLY     = 8'h8C;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;
    localparam logic [COUNT_W-1:0] MAX_DEV_RST  = 8'hFF;

    localparam logic [1:0] FUNC_RESTART = 2'd0;
    localparam logic [1:0] FUNC_BEGIN   = 2'd1;
    localparam logic [1:0] FUNC_BIT     = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    typedef enum logic [2:0] {
        ST_BUSY            = 3'd0,
        ST_FOUND           = 3'd1,
        ST_NO_PRESENCE     = 3'd2,
        ST_NO_PARTICIPANTS = 3'd3,
        ST_BAD_CODE        = 3'd4,
        ST_COMPLETE        = 3'd5,
        ST_IGNORED         = 3'd6
    } status_t;

    typedef struct packed {
        logic [POS_W-1:0]    last_disc;
        logic [FAM_W-1:0]    last_family;
        logic                all_found;
        logic                pass_active;
        logic [POS_W-1:0]    bit_pos;
        logic [POS_W-1:0]    zero_pick_pos;
        logic [ROM_BITS-1:0] rom_accum;
        logic [ROM_BITS-1:0] prev_rom;
        logic [CRC_W-1:0]    crc;
        logic [COUNT_W-1:0]  found_count;
    } search_state_t;

    typedef struct packed {
        logic                direction;
        logic                write_valid;
        logic                pass_done;
        status_t             status;
        logic [ROM_BITS-1:0] rom_id;
        logic [FAM_W-1:0]    family_disc;
        logic [COUNT_W-1:0]  device_count;
    } search_result_t;

endpackage

/* hdl/onewire_rom_search.sv */
// Top level of the 1-Wire ROM search engine: request/result registers and search state.
`timescale 1ns / 1ps

//  channel   handshake              payload
//  request   in_valid / in_stall    func, presence, true_bit, complement_bit
//  result    out_valid / out_stall  direction, write_valid, pass_done, status,
//                                   rom_id, family_discrepancy, device_count
//  config    cfg_we                 cfg_wdata (max_devices)
//
// One request per cycle sustained while out_stall is low; each request gives exactly one result.
// A request passes through the request register, then the search step logic
// (bit compare, ROM bit set, one serial CRC-8 step) into the result register.
// Search state updates when a request moves into the result register.
// A stalled result holds the request register; in_stall rises only when both
// registers are full and out_stall is high.
// Reset clears the valid flags and the search state (bit_pos restarts at 1); max_devices resets to 255.

module onewire_rom_search
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic        presence,
    input  logic        true_bit,
    input  logic        complement_bit,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        direction,
    output logic        write_valid,
    output logic        pass_done,
    output logic [2:0]  status,
    output logic [63:0] rom_id,
    output logic [3:0]  family_discrepancy,
    output logic [7:0]  device_count
);
    import ors_pkg::*;

    logic [COUNT_W-1:0] max_devices_reg;

    // request register
    logic               in_valid_reg;
    logic [1:0]         func_reg;
    logic               presence_reg;
    logic               true_bit_reg;
    logic               complement_bit_reg;

    // search state
    search_state_t      state_reg;
    search_state_t      state_next;

    // result register
    logic               out_valid_reg;
    search_result_t     res_reg;
    search_result_t     res_next;

    logic               advance;

    // request moves on when the result register is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    ors_step u_step
    (
        .cur            (state_reg),
        .func           (func_reg),
        .presence       (presence_reg),
        .true_bit       (true_bit_reg),
        .complement_bit (complement_bit_reg),
        .max_devices    (max_devices_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_devices_reg <= MAX_DEV_RST;
        end
        else if (cfg_we)
        begin
            max_devices_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // request payload, captured on acceptance
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            func_reg           <= func;
            presence_reg       <= presence;
            true_bit_reg       <= true_bit;
            complement_bit_reg <= complement_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.last_disc     <= '0;
            state_reg.last_family   <= '0;
            state_reg.all_found     <= 1'b0;
            state_reg.pass_active   <= 1'b0;
            state_reg.bit_pos       <= POS_W'(1);
            state_reg.zero_pick_pos <= '0;
            state_reg.rom_accum     <= '0;
            state_reg.prev_rom      <= '0;
            state_reg.crc           <= '0;
            state_reg.found_count   <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign direction          = res_reg.direction;
    assign write_valid        = res_reg.write_valid;
    assign pass_done          = res_reg.pass_done;
    assign status             = res_reg.status;
    assign rom_id             = res_reg.rom_id;
    assign family_discrepancy = res_reg.family_disc;
    assign device_count       = res_reg.device_count;

endmodule

/* hdl/ors_step.sv */
// Per-request search step: next search state and the result for one request.
`timescale 1ns / 1ps

module ors_step
(
    input  ors_pkg::search_state_t  cur,
    input  logic [1:0]              func,
    input  logic                    presence,
    input  logic                    true_bit,
    input  logic                    complement_bit,
    input  logic [7:0]              max_devices,
    output ors_pkg::search_state_t  nxt,
    output ors_pkg::search_result_t res
);
    import ors_pkg::*;

    logic [IDX_W-1:0]    idx;
    logic                dir;
    logic                fb;
    logic [CRC_W-1:0]    crc_upd;
    logic [ROM_BITS-1:0] rom_upd;
    logic [POS_W-1:0]    pos_upd;

    // Bit-pair datapath, used only when a pass is running
    always_comb
    begin
        idx = cur.bit_pos[IDX_W-1:0] - IDX_W'(1);
        if (true_bit != complement_bit)
        begin
            dir = true_bit;
        end
        else if (cur.bit_pos < cur.last_disc)
        begin
            dir = cur.prev_rom[idx];
        end
        else
        begin
            dir = (cur.bit_pos == cur.last_disc);
        end
        rom_upd = cur.rom_accum | ({{(ROM_BITS-1){1'b0}}, dir} << idx);
        fb      = cur.crc[0] ^ dir;
        crc_upd = {1'b0, cur.crc[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
        pos_upd = cur.bit_pos + POS_W'(1);
    end

    always_comb
    begin
        nxt             = cur;
        res.direction   = 1'b0;
        res.write_valid = 1'b0;
        res.pass_done   = 1'b0;
        res.status      = ST_BUSY;

        case (func)
            FUNC_RESTART:
            begin
                nxt.last_disc   = '0;
                nxt.last_family = '0;
                nxt.all_found   = 1'b0;
                nxt.found_count = '0;
                nxt.pass_active = 1'b0;
            end
            FUNC_BEGIN:
            begin
                nxt.pass_active = 1'b0;
                if (cur.all_found || (cur.found_count >= max_devices))
                begin
                    res.pass_done = 1'b1;
                    res.status    = ST_COMPLETE;
                end
                else if (!presence)
                begin
                    res.pass_done = 1'b1;
                    res.status    = ST_NO_PRESENCE;
                end
                else
                begin
                    nxt.pass_active   = 1'b1;
                    nxt.bit_pos       = POS_W'(1);
                    nxt.zero_pick_pos = '0;
                    nxt.rom_accum     = '0;
                    nxt.crc           = '0;
                end
            end
            FUNC_BIT:
            begin
                if (!cur.pass_active)
                begin
                    res.status = ST_IGNORED;
                end
                else if (true_bit && complement_bit)
                begin
                    nxt.pass_active = 1'b0;
                    res.pass_done   = 1'b1;
                    res.status      = ST_NO_PARTICIPANTS;
                end
                else
                begin
                    // zero taken at a discrepancy: remember where
                    if ((true_bit == complement_bit) && !dir)
                    begin
                        nxt.zero_pick_pos = cur.bit_pos;
                        if (cur.bit_pos < FAMILY_LIMIT)
                        begin
                            nxt.last_family = cur.bit_pos[FAM_W-1:0];
                        end
                    end
                    nxt.rom_accum   = rom_upd;
                    nxt.crc         = crc_upd;
                    nxt.bit_pos     = pos_upd;
                    res.direction   = dir;
                    res.write_valid = 1'b1;
                    if (pos_upd > LAST_BIT_POS)
                    begin
                        nxt.pass_active = 1'b0;
                        res.pass_done   = 1'b1;
                        if ((crc_upd != '0) || (rom_upd[7:0] == 8'h00))
                        begin
                            res.status = ST_BAD_CODE;
                        end
                        else
                        begin
                            res.status    = ST_FOUND;
                            nxt.prev_rom  = rom_upd;
                            nxt.last_disc = nxt.zero_pick_pos;
                            if (nxt.zero_pick_pos == '0)
                            begin
                                nxt.all_found = 1'b1;
                            end
                            if (cur.found_count < COUNT_MAX)
                            begin
                                nxt.found_count = cur.found_count + COUNT_W'(1);
                            end
                        end
                    end
                end
            end
            default:
            begin
                res.status = ST_IGNORED;
            end
        endcase

        res.rom_id       = nxt.rom_accum;
        res.family_disc  = nxt.last_family;
        res.device_count = nxt.found_count;
    end

endmodule
